// File: hdl/sed_pkg.sv
// Shared types and constants for the string escape decoder.
// Used by sed_front, sed_queue, sed_back and string_escape_decoder; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

  // Most result bytes that one input byte can produce (a 4-byte UTF-8 sequence)
  localparam int MaxRes = 4;
  localparam int ResCntW = 3;

  // Decoder modes
  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_OCT     = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_U4      = 3'd4,
    MODE_U8      = 3'd5,
    MODE_DISCARD = 3'd6
  } mode_e;

  // Character codes
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChLowA      = 8'h61;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChLowN      = 8'h6e;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowV      = 8'h76;
  localparam logic [7:0] ChLowX      = 8'h78;
  localparam logic [7:0] ChLowU      = 8'h75;
  localparam logic [7:0] ChUpU       = 8'h55;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChEight     = 8'h38;
  localparam logic [7:0] ChNine      = 8'h39;

  // Control codes produced by the single-character escapes
  localparam logic [7:0] CodeBell = 8'h07;
  localparam logic [7:0] CodeBs   = 8'h08;
  localparam logic [7:0] CodeFf   = 8'h0c;
  localparam logic [7:0] CodeLf   = 8'h0a;
  localparam logic [7:0] CodeCr   = 8'h0d;
  localparam logic [7:0] CodeTab  = 8'h09;
  localparam logic [7:0] CodeVt   = 8'h0b;

  // Result group for one input byte: cnt results, string_end on the last one
  typedef struct packed {
    logic [ResCntW-1:0]        cnt;
    logic [MaxRes-1:0][7:0]    data;
    logic [MaxRes-1:0]         has;
    logic [MaxRes-1:0]         err;
    logic                      str_end;
  } group_t;

endpackage

`default_nettype wire

// File: hdl/sed_front.sv
// Front end: decodes one accepted byte per cycle into a result group.
// Depends on sed_pkg (mode_e, group_t, character constants).
`timescale 1ns / 1ps
`default_nettype none

module sed_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            last_byte_i,
  input  wire logic            raw_mode_i,
  output sed_pkg::group_t      grp_o,
  output logic                 grp_valid_o
);

  sed_pkg::mode_e mode_q, mode_d;
  logic [3:0]     cnt_q, cnt_d;
  logic [31:0]    acc_q, acc_d;

  // Append one result to a group
  function automatic sed_pkg::group_t push_res(input sed_pkg::group_t g,
                                               input logic [7:0] b,
                                               input logic h,
                                               input logic e);
    sed_pkg::group_t r;
    r = g;
    r.data[g.cnt[1:0]] = b;
    r.has[g.cnt[1:0]]  = h;
    r.err[g.cnt[1:0]]  = e;
    r.cnt              = g.cnt + 3'd1;
    return r;
  endfunction

  // Hex digit value; bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  logic [4:0]      hv;
  logic [3:0]      need;
  logic            plain_go;
  logic            is_oct;
  logic [31:0]     cp;
  sed_pkg::group_t g;

  // Decode the byte against the current mode
  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    g        = '0;
    plain_go = 1'b0;
    hv       = hex_val(in_byte_i);
    is_oct   = (in_byte_i >= sed_pkg::ChZero) && (in_byte_i <= sed_pkg::ChSeven);
    cp       = {acc_q[27:0], hv[3:0]};
    case (mode_q)
      sed_pkg::MODE_HEX: need = 4'd2;
      sed_pkg::MODE_U4:  need = 4'd4;
      default:           need = 4'd8;
    endcase

    case (mode_q)
      sed_pkg::MODE_ESC: begin
        mode_d = sed_pkg::MODE_PLAIN;
        cnt_d  = 4'd0;
        acc_d  = 32'd0;
        case (in_byte_i)
          sed_pkg::ChLowA:      g = push_res(g, sed_pkg::CodeBell, 1'b1, 1'b0);
          sed_pkg::ChLowB:      g = push_res(g, sed_pkg::CodeBs, 1'b1, 1'b0);
          sed_pkg::ChLowF:      g = push_res(g, sed_pkg::CodeFf, 1'b1, 1'b0);
          sed_pkg::ChLowN:      g = push_res(g, sed_pkg::CodeLf, 1'b1, 1'b0);
          sed_pkg::ChLowR:      g = push_res(g, sed_pkg::CodeCr, 1'b1, 1'b0);
          sed_pkg::ChLowT:      g = push_res(g, sed_pkg::CodeTab, 1'b1, 1'b0);
          sed_pkg::ChLowV:      g = push_res(g, sed_pkg::CodeVt, 1'b1, 1'b0);
          sed_pkg::ChBackslash,
          sed_pkg::ChDquote,
          sed_pkg::ChSquote:    g = push_res(g, in_byte_i, 1'b1, 1'b0);
          sed_pkg::ChNewline: ; // escaped newline: drop
          default: begin
            if (is_oct) begin
              if (last_byte_i) begin
                g = push_res(g, {5'd0, in_byte_i[2:0]}, 1'b1, 1'b0);
              end else begin
                mode_d = sed_pkg::MODE_OCT;
                cnt_d  = 4'd1;
                acc_d  = {29'd0, in_byte_i[2:0]};
              end
            end else if (!last_byte_i && in_byte_i == sed_pkg::ChLowX) begin
              mode_d = sed_pkg::MODE_HEX;
            end else if (!last_byte_i && in_byte_i == sed_pkg::ChLowU) begin
              mode_d = sed_pkg::MODE_U4;
            end else if (!last_byte_i && in_byte_i == sed_pkg::ChUpU) begin
              mode_d = sed_pkg::MODE_U8;
            end else begin
              g      = push_res(g, 8'd0, 1'b0, 1'b1);
              mode_d = sed_pkg::MODE_DISCARD;
            end
          end
        endcase
      end

      sed_pkg::MODE_OCT: begin
        if (is_oct) begin
          acc_d = {acc_q[28:0], in_byte_i[2:0]};
          cnt_d = cnt_q + 4'd1;
          if (cnt_d >= 4'd3 || last_byte_i) begin
            g      = push_res(g, acc_d[7:0], 1'b1, 1'b0);
            mode_d = sed_pkg::MODE_PLAIN;
            cnt_d  = 4'd0;
            acc_d  = 32'd0;
          end
        end else if (in_byte_i == sed_pkg::ChEight || in_byte_i == sed_pkg::ChNine) begin
          g      = push_res(g, 8'd0, 1'b0, 1'b1);
          mode_d = sed_pkg::MODE_DISCARD;
          cnt_d  = 4'd0;
          acc_d  = 32'd0;
        end else begin
          // close the octal run, then treat the byte as plain text
          g        = push_res(g, acc_q[7:0], 1'b1, 1'b0);
          mode_d   = sed_pkg::MODE_PLAIN;
          cnt_d    = 4'd0;
          acc_d    = 32'd0;
          plain_go = 1'b1;
        end
      end

      sed_pkg::MODE_HEX,
      sed_pkg::MODE_U4,
      sed_pkg::MODE_U8: begin
        if (!hv[4]) begin
          g      = push_res(g, 8'd0, 1'b0, 1'b1);
          mode_d = sed_pkg::MODE_DISCARD;
          cnt_d  = 4'd0;
          acc_d  = 32'd0;
        end else begin
          acc_d = cp;
          cnt_d = cnt_q + 4'd1;
          if (cnt_d >= need) begin
            mode_d = sed_pkg::MODE_PLAIN;
            cnt_d  = 4'd0;
            acc_d  = 32'd0;
            if (mode_q == sed_pkg::MODE_HEX) begin
              g = push_res(g, cp[7:0], 1'b1, 1'b0);
            end else if (cp > 32'h0010_ffff || (cp >= 32'h0000_d800 && cp <= 32'h0000_dfff)) begin
              g      = push_res(g, 8'd0, 1'b0, 1'b1);
              mode_d = sed_pkg::MODE_DISCARD;
            end else if (cp < 32'h0000_0080) begin
              g = push_res(g, cp[7:0], 1'b1, 1'b0);
            end else if (cp < 32'h0000_0800) begin
              g = push_res(g, {3'b110, cp[10:6]}, 1'b1, 1'b0);
              g = push_res(g, {2'b10, cp[5:0]}, 1'b1, 1'b0);
            end else if (cp < 32'h0001_0000) begin
              g = push_res(g, {4'b1110, cp[15:12]}, 1'b1, 1'b0);
              g = push_res(g, {2'b10, cp[11:6]}, 1'b1, 1'b0);
              g = push_res(g, {2'b10, cp[5:0]}, 1'b1, 1'b0);
            end else begin
              g = push_res(g, {5'b11110, cp[20:18]}, 1'b1, 1'b0);
              g = push_res(g, {2'b10, cp[17:12]}, 1'b1, 1'b0);
              g = push_res(g, {2'b10, cp[11:6]}, 1'b1, 1'b0);
              g = push_res(g, {2'b10, cp[5:0]}, 1'b1, 1'b0);
            end
          end else if (last_byte_i) begin
            // truncated escape
            g      = push_res(g, 8'd0, 1'b0, 1'b1);
            mode_d = sed_pkg::MODE_DISCARD;
            cnt_d  = 4'd0;
            acc_d  = 32'd0;
          end
        end
      end

      sed_pkg::MODE_DISCARD: begin
        if (last_byte_i) begin
          g = push_res(g, 8'd0, 1'b0, 1'b1);
        end
      end

      default: plain_go = 1'b1;
    endcase

    // Plain text handling
    if (plain_go) begin
      if (raw_mode_i || in_byte_i != sed_pkg::ChBackslash) begin
        g = push_res(g, in_byte_i, 1'b1, 1'b0);
      end else if (last_byte_i) begin
        g      = push_res(g, 8'd0, 1'b0, 1'b1);
        mode_d = sed_pkg::MODE_DISCARD;
        cnt_d  = 4'd0;
        acc_d  = 32'd0;
      end else begin
        mode_d = sed_pkg::MODE_ESC;
      end
    end

    // Close the string
    if (last_byte_i) begin
      if (g.cnt == 3'd0) begin
        g = push_res(g, 8'd0, 1'b0, 1'b0);
      end
      g.str_end = 1'b1;
      mode_d    = sed_pkg::MODE_PLAIN;
      cnt_d     = 4'd0;
      acc_d     = 32'd0;
    end
  end

  assign grp_o       = g;
  assign grp_valid_o = accept_i && (g.cnt != 3'd0);

  // Advance decoder state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sed_pkg::MODE_PLAIN;
      cnt_q  <= 4'd0;
      acc_q  <= 32'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
    end
  end

`ifndef SYNTHESIS
  // A string's last byte always leaves the decoder in plain text mode
  a_end_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_byte_i) |=> (mode_q == sed_pkg::MODE_PLAIN && cnt_q == 4'd0))
    else $error("decoder not back in plain mode after last byte");

  // An octal run waits with one or two digits only
  a_oct_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == sed_pkg::MODE_OCT) |-> (cnt_q == 4'd1 || cnt_q == 4'd2))
    else $error("octal digit count out of range");

  // A last byte always yields at least one result
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_byte_i) |-> grp_valid_o)
    else $error("last byte produced no result");
`endif

endmodule

`default_nettype wire

// File: hdl/sed_queue.sv
// Short queue of result groups between the decoder and the output serializer.
// Depends on sed_pkg (group_t).
`timescale 1ns / 1ps
`default_nettype none

module sed_queue #(
  parameter int Depth = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  sed_pkg::group_t      wr_data_i,
  input  wire logic            rd_i,
  output sed_pkg::group_t      rd_data_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  sed_pkg::group_t    store_q [Depth];
  logic [AW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]      count_q;
  logic               do_wr, do_rd;

  assign full_o    = (count_q == CW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = store_q[rd_ptr_q];

  // Write entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      store_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // Fill level stays within the queue depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("queue count exceeds depth");

  // Pointers meet while the queue is empty
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers differ while empty");

  // A stored group is never empty
  a_head_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (rd_data_o.cnt != 3'd0 && rd_data_o.cnt <= 3'd4))
    else $error("queue head holds an empty group");
`endif

endmodule

`default_nettype wire

// File: hdl/sed_back.sv
// Back end: sends the results of the head group out one per pop.
// Depends on sed_pkg (group_t).
`timescale 1ns / 1ps
`default_nettype none

module sed_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  sed_pkg::group_t      head_i,
  input  wire logic            head_empty_i,
  input  wire logic            pop_i,
  output logic                 head_rd_o,
  output logic [7:0]           out_byte_o,
  output logic                 has_byte_o,
  output logic                 string_end_o,
  output logic                 escape_error_o,
  output logic                 run_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       at_last;
  logic       take;

  assign at_last = ({1'b0, idx_q} == (head_i.cnt - 3'd1));
  assign take    = pop_i && !head_empty_i;

  // Present the selected result of the head group
  assign out_byte_o     = head_i.data[idx_q];
  assign has_byte_o     = head_i.has[idx_q];
  assign escape_error_o = head_i.err[idx_q];
  assign string_end_o   = head_i.str_end && at_last;
  assign run_last_o     = at_last;
  assign head_rd_o      = take && at_last;

  // Step through the group; release it after its last result
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = at_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef SYNTHESIS
  // Result index stays inside the head group
  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_empty_i |-> ({1'b0, idx_q} < head_i.cnt))
    else $error("result index beyond head group");

  // A new group always starts at its first result
  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_rd_o |=> (idx_q == 2'd0))
    else $error("index not reset after group release");

  // Nothing to step through while the queue is empty
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_empty_i |-> (idx_q == 2'd0))
    else $error("index moved with no group waiting");
`endif

endmodule

`default_nettype wire

// File: hdl/string_escape_decoder.sv
// Top level of the string escape decoder: front decoder, group queue, serializer.
// Depends on sed_pkg, sed_front, sed_queue and sed_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------------
//   input    | push / full        | in_byte_i, last_byte_i, raw_mode_i
//   result   | pop / empty        | out_byte_o, has_byte_o, string_end_o,
//            |                    | escape_error_o, run_last_o
//
// One byte is accepted per cycle while the group queue has room; it is decoded
// in the cycle it is accepted and its results (1 to 4) enter the queue as one group;
// it is stored there, and its first result reaches the ports once groups ahead of it
// have left; a byte with none writes nothing. Results leave one per cycle while pop
// is high and a group waits; the queue of QUEUE_DEPTH groups absorbs the difference.
// Reset clears the decoder to plain text mode and empties the queue; no clearing pass.
// full depends only on the queue fill level, empty only on whether a group waits.
`timescale 1ns / 1ps
`default_nettype none

module string_escape_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       raw_mode_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            has_byte_o,
  output logic            string_end_o,
  output logic            escape_error_o,
  output logic            run_last_o
);

  sed_pkg::group_t grp, head;
  logic            grp_valid;
  logic            accept;
  logic            head_rd;
  logic            q_full, q_empty;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign empty  = q_empty;

  sed_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .raw_mode_i  (raw_mode_i),
    .grp_o       (grp),
    .grp_valid_o (grp_valid)
  );

  sed_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (grp_valid),
    .wr_data_i (grp),
    .rd_i      (head_rd),
    .rd_data_o (head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  sed_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_empty_i   (q_empty),
    .pop_i          (pop),
    .head_rd_o      (head_rd),
    .out_byte_o     (out_byte_o),
    .has_byte_o     (has_byte_o),
    .string_end_o   (string_end_o),
    .escape_error_o (escape_error_o),
    .run_last_o     (run_last_o)
  );

endmodule

`default_nettype wire
